[rtl/core/rpd_pkg.sv]
// ---------------------------------------------------------------------------
// rpd_pkg
// shared types and constants of the run-length pixel decoder
// ---------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

   localparam int unsigned MAX_FRAME_PIXELS = 131072;
   localparam int unsigned CNT_W            = $clog2(MAX_FRAME_PIXELS + 1);
   localparam int unsigned FRAME_W          = 18;
   localparam int unsigned SUM_W            = ((CNT_W > FRAME_W) ? CNT_W : FRAME_W) + 1;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned PIXEL_W          = 16;
   localparam int unsigned RUN_W            = 7;

   localparam logic [FRAME_W-1:0] FRAME_PIXELS_RESET = FRAME_W'(130560);

   // request from the decoder to the frame counter
   typedef struct packed {
      logic             add;
      logic             check;
      logic [RUN_W-1:0] count;
   } count_req_type;

endpackage

`default_nettype wire

[rtl/core/rpd_frame_counter.sv]
// ---------------------------------------------------------------------------
// rpd_frame_counter
// frame size register and saturating pixel counter, flags the frame end
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_frame_counter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [rpd_pkg::FRAME_W-1:0]    csr_wr_data,
   input  wire rpd_pkg::count_req_type         count_req,
   output logic                                frame_end
);

   logic [rpd_pkg::FRAME_W-1:0] frame_ff;
   logic [rpd_pkg::CNT_W-1:0]   done_ff;
   logic [rpd_pkg::CNT_W-1:0]   done_in;
   logic [rpd_pkg::SUM_W-1:0]   sum;
   logic [rpd_pkg::SUM_W-1:0]   sat;
   logic [rpd_pkg::SUM_W-1:0]   limit;
   logic [rpd_pkg::SUM_W-1:0]   max_pix;

   always_comb begin
      max_pix = rpd_pkg::SUM_W'(rpd_pkg::MAX_FRAME_PIXELS);
      sum     = rpd_pkg::SUM_W'(done_ff) + rpd_pkg::SUM_W'(count_req.count);
      sat     = (sum > max_pix) ? max_pix : sum;
      limit   = (rpd_pkg::SUM_W'(frame_ff) > max_pix) ? max_pix
                                                      : rpd_pkg::SUM_W'(frame_ff);
      frame_end = 1'b0;
      done_in   = done_ff;
      if (count_req.add) begin
         if (count_req.check && (sat >= limit)) begin
            frame_end = 1'b1;
            done_in   = '0;
         end else begin
            done_in   = rpd_pkg::CNT_W'(sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= rpd_pkg::FRAME_PIXELS_RESET;
         done_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            frame_ff <= csr_wr_data;
         end
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rpd_decode.sv]
// ---------------------------------------------------------------------------
// rpd_decode
// byte phase tracking: headers, pixel byte pairs and run bookkeeping
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [rpd_pkg::BYTE_W-1:0]    code_byte,
   output logic                               emit,
   output logic [rpd_pkg::PIXEL_W-1:0]        pixel_value,
   output logic [rpd_pkg::RUN_W-1:0]          run_length,
   output rpd_pkg::count_req_type             count_req
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LOW,
      PH_HIGH
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic                           repeat_ff, repeat_in;
   logic [rpd_pkg::RUN_W-1:0]      left_ff, left_in;
   logic [rpd_pkg::BYTE_W-1:0]     low_ff, low_in;
   logic [rpd_pkg::RUN_W-1:0]      left_dec;

   always_comb begin
      phase_in    = phase_ff;
      repeat_in   = repeat_ff;
      left_in     = left_ff;
      low_in      = low_ff;
      emit        = 1'b0;
      pixel_value = {code_byte, low_ff};
      run_length  = rpd_pkg::RUN_W'(1);
      count_req   = '0;
      left_dec    = left_ff - rpd_pkg::RUN_W'(left_ff != '0);
      unique case (phase_ff)
         PH_LOW: begin
            low_in   = code_byte;
            phase_in = PH_HIGH;
         end
         PH_HIGH: begin
            if (repeat_ff) begin
               phase_in   = PH_HEADER;
               left_in    = '0;
               run_length = left_ff;
               if (left_ff != '0) begin
                  emit = 1'b1;
               end
               count_req.check = 1'b1;
               count_req.count = left_ff;
            end else begin
               emit            = 1'b1;
               left_in         = left_dec;
               count_req.count = rpd_pkg::RUN_W'(1);
               if (left_dec == '0) begin
                  phase_in        = PH_HEADER;
                  count_req.check = 1'b1;
               end else begin
                  phase_in        = PH_LOW;
               end
            end
         end
         default: begin
            repeat_in = code_byte[rpd_pkg::BYTE_W-1];
            left_in   = code_byte[rpd_pkg::RUN_W-1:0];
            if (code_byte != '0) begin
               phase_in = PH_LOW;
            end else begin
               phase_in = PH_HEADER;
            end
         end
      endcase
      emit          = emit & step;
      count_req.add = emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         repeat_ff <= 1'b0;
         left_ff   <= '0;
         low_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         repeat_ff <= repeat_in;
         left_ff   <= left_in;
         low_ff    <= low_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rle_pixel_decoder_core.sv]
// ---------------------------------------------------------------------------
// rle_pixel_decoder_core
// run-length decoder for a 16-bit pixel stream, one byte per request
// ---------------------------------------------------------------------------
// The block takes one encoded byte per clock cycle and keeps that rate as
// long as results are taken. A byte goes into an input register, is decoded
// from there against the phase state and the frame counter once the output
// register can advance, and any result lands in that output register. A
// literal pixel gives one result every two bytes; a repeat run gives a
// single result carrying its length. rsp_tlast marks the result that ends a
// run and brings the frame to or past the frame size written through
// csr_wr_data. The user must write the frame size only while the block is
// idle; the block itself does not enforce this.
`default_nettype none

module rle_pixel_decoder_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,   // code_byte[7:0]
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [23:0]                               rsp_tdata,   // pixel_value[15:0], run_length[22:16], zero[23]
   output logic                                      rsp_tlast,   // frame_end
   input  wire logic                                 csr_wr_en,
   input  wire logic [rpd_pkg::FRAME_W-1:0]          csr_wr_data  // frame_pixels
);

   logic                            in_valid_ff, in_valid_in;
   logic [rpd_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [rpd_pkg::PIXEL_W-1:0]     out_pixel_ff;
   logic [rpd_pkg::RUN_W-1:0]       out_len_ff;
   logic                            out_last_ff;
   logic                            advance;
   logic                            step;
   logic                            emit;
   logic [rpd_pkg::PIXEL_W-1:0]     pixel_value;
   logic [rpd_pkg::RUN_W-1:0]       run_length;
   logic                            frame_end;
   rpd_pkg::count_req_type          count_req;

   assign advance      = !out_valid_ff || rsp_tready;
   assign step         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? emit : out_valid_ff;

   rpd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .code_byte   (in_byte_ff),
      .emit        (emit),
      .pixel_value (pixel_value),
      .run_length  (run_length),
      .count_req   (count_req)
   );

   rpd_frame_counter u_frame_counter (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .count_req   (count_req),
      .frame_end   (frame_end)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_pixel_ff <= pixel_value;
         out_len_ff   <= run_length;
         out_last_ff  <= frame_end;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_len_ff, out_pixel_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

[rtl/core/rpd_checker.sv]
// ---------------------------------------------------------------------------
// rpd_checker
// port-level checks of the run-length pixel decoder
// ---------------------------------------------------------------------------
`default_nettype none

module rpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // no zero-length run ever leaves the block
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:16] != 7'd0)
      else $error("response with zero run length");

   // pad bit stays clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[23])
      else $error("response pad bit set");

   // a fresh result must be preceded by a taken request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without matching request");

endmodule

bind rle_pixel_decoder_core rpd_checker u_rpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
